@@ hw/rtl/utf8_replacement_decoder_assert.svh @@
// Assertion macros shared by the decoder RTL.
// Included by the modules that carry concurrent checks; no dependencies.
`ifndef UTF8_REPLACEMENT_DECODER_ASSERT_SVH
`define UTF8_REPLACEMENT_DECODER_ASSERT_SVH

// check cons in the same cycle as ante
`define U8RD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8rd assertion failed");

// check cons in the cycle after ante
`define U8RD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8rd assertion failed");

`endif

@@ hw/rtl/utf8rd_pkg.sv @@
// Package for the UTF-8 replacement decoder: byte codes, run type, queue depth.
// No dependencies; used by the front end, queue, back end and top level.
package utf8rd_pkg;

    localparam int unsigned RUN_MAX     = 6;
    localparam int unsigned RUN_CNT_W   = $clog2(RUN_MAX + 1);
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] LEAD_E0   = 8'hE0;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] LEAD_F0   = 8'hF0;
    localparam logic [7:0] LEAD_F4   = 8'hF4;
    localparam logic [7:0] TAIL_MASK = 8'hC0;
    localparam logic [7:0] TAIL_TAG  = 8'h80;
    localparam logic [7:0] ASCII_END = 8'h80;
    localparam logic [7:0] TAIL_A0   = 8'hA0;
    localparam logic [7:0] TAIL_90   = 8'h90;
    localparam logic [7:0] REPL_0    = 8'hEF;
    localparam logic [7:0] REPL_1    = 8'hBF;
    localparam logic [7:0] REPL_2    = 8'hBD;

    // one decoded item: bytes to send, how many, and the overflow flag they carry
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    cnt;
        logic                    flag;
    } t_run;

    typedef struct packed {
        logic valid;
        t_run run;
    } t_push;

endpackage

@@ hw/rtl/utf8rd_if.sv @@
// Channel interfaces of the decoder: input bytes, output bytes, limit writes.
// No dependencies.
interface utf8rd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;
    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utf8rd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       limit_exceeded;
    modport source (output valid, output out_byte, output last_of_run,
                    output limit_exceeded, input ready);
    modport sink (input valid, input out_byte, input last_of_run,
                  input limit_exceeded, output ready);
endinterface

interface utf8rd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] output_limit;
    modport source (output valid, output output_limit, input ready);
    modport sink (input valid, input output_limit, output ready);
endinterface

@@ hw/rtl/utf8rd_front.sv @@
// Front end: accepts bytes, runs the UTF-8 sequence state, applies the output limit.
// Depends on utf8rd_pkg, utf8rd_if and the assertion header.
`include "utf8_replacement_decoder_assert.svh"

module utf8rd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utf8rd_in_if.sink            i_in,
    utf8rd_cfg_if.sink           i_cfg,
    input  logic                 i_q_ready,
    output utf8rd_pkg::t_push    o_push
);

    logic [31:0] r_limit;
    logic [31:0] r_count, n_count;
    logic        r_over, n_over;
    logic [7:0]  r_lead, n_lead;
    logic [1:0]  r_need, n_need;
    logic [1:0]  r_seen, n_seen;
    logic [7:0]  r_held [2];

    logic        acc;
    logic [7:0]  b;
    logic [1:0]  f_need;
    logic [1:0]  f_len;
    logic [7:0]  f0, f1, f2;
    logic        tail_good;
    logic        complete;
    logic        hold_wr;
    logic [utf8rd_pkg::RUN_MAX-1:0][7:0] run_bytes;
    logic [utf8rd_pkg::RUN_CNT_W-1:0]    run_len;
    logic [utf8rd_pkg::RUN_CNT_W-1:0]    keep;
    logic [31:0] room;
    logic        has_room;
    logic        dropped;

    assign i_in.ready  = i_q_ready;
    assign i_cfg.ready = 1'b1;
    assign acc = i_in.valid && i_in.ready;
    assign b   = i_in.data_byte;

    always_comb begin
        f_need = 2'd0;
        if (b >= utf8rd_pkg::LEAD2_LO && b <= utf8rd_pkg::LEAD2_HI) begin
            f_need = 2'd1;
        end else if (b >= utf8rd_pkg::LEAD3_LO && b <= utf8rd_pkg::LEAD3_HI) begin
            f_need = 2'd2;
        end else if (b >= utf8rd_pkg::LEAD4_LO && b <= utf8rd_pkg::LEAD4_HI) begin
            f_need = 2'd3;
        end
        if (b < utf8rd_pkg::ASCII_END) begin
            f_len = 2'd1;
            f0 = b;
            f1 = utf8rd_pkg::REPL_1;
            f2 = utf8rd_pkg::REPL_2;
        end else begin
            f_len = (f_need == 2'd0) ? 2'd3 : 2'd0;
            f0 = utf8rd_pkg::REPL_0;
            f1 = utf8rd_pkg::REPL_1;
            f2 = utf8rd_pkg::REPL_2;
        end
    end

    always_comb begin
        tail_good = (b & utf8rd_pkg::TAIL_MASK) == utf8rd_pkg::TAIL_TAG;
        if (r_seen == 2'd0) begin
            if (r_lead == utf8rd_pkg::LEAD_E0 && b < utf8rd_pkg::TAIL_A0) tail_good = 1'b0;
            if (r_lead == utf8rd_pkg::LEAD_ED && b >= utf8rd_pkg::TAIL_A0) tail_good = 1'b0;
            if (r_lead == utf8rd_pkg::LEAD_F0 && b < utf8rd_pkg::TAIL_90) tail_good = 1'b0;
            if (r_lead == utf8rd_pkg::LEAD_F4 && b >= utf8rd_pkg::TAIL_90) tail_good = 1'b0;
        end
        complete = (2'(r_seen + 2'd1) == r_need);
    end

    always_comb begin
        run_bytes = '0;
        run_len   = '0;
        n_lead    = r_lead;
        n_need    = r_need;
        n_seen    = r_seen;
        hold_wr   = 1'b0;
        if (i_in.end_of_text) begin
            run_bytes[0] = utf8rd_pkg::REPL_0;
            run_bytes[1] = utf8rd_pkg::REPL_1;
            run_bytes[2] = utf8rd_pkg::REPL_2;
            run_len = (r_need != 2'd0) ? utf8rd_pkg::RUN_CNT_W'(3) : '0;
            n_lead = '0;
            n_need = '0;
            n_seen = '0;
        end else if (r_need == 2'd0 || !tail_good) begin
            if (r_need == 2'd0) begin
                run_bytes[0] = f0;
                run_bytes[1] = f1;
                run_bytes[2] = f2;
                run_len = utf8rd_pkg::RUN_CNT_W'(f_len);
            end else begin
                run_bytes[0] = utf8rd_pkg::REPL_0;
                run_bytes[1] = utf8rd_pkg::REPL_1;
                run_bytes[2] = utf8rd_pkg::REPL_2;
                run_bytes[3] = f0;
                run_bytes[4] = f1;
                run_bytes[5] = f2;
                run_len = utf8rd_pkg::RUN_CNT_W'(f_len) + utf8rd_pkg::RUN_CNT_W'(3);
            end
            n_lead = (f_need != 2'd0) ? b : '0;
            n_need = f_need;
            n_seen = '0;
        end else if (complete) begin
            run_bytes[0] = r_lead;
            run_bytes[1] = (r_seen == 2'd0) ? b : r_held[0];
            run_bytes[2] = (r_seen == 2'd1) ? b : r_held[1];
            run_bytes[3] = b;
            run_len = utf8rd_pkg::RUN_CNT_W'(r_need) + utf8rd_pkg::RUN_CNT_W'(1);
            n_lead = '0;
            n_need = '0;
            n_seen = '0;
        end else begin
            hold_wr = 1'b1;
            n_seen = 2'(r_seen + 2'd1);
        end
    end

    always_comb begin
        has_room = r_count < r_limit;
        room     = r_limit - r_count;
        if (!has_room) begin
            keep = '0;
        end else if (room < 32'(run_len)) begin
            keep = room[utf8rd_pkg::RUN_CNT_W-1:0];
        end else begin
            keep = run_len;
        end
        dropped = keep < run_len;
        n_count = r_count + 32'(keep);
        n_over  = r_over | dropped;
        o_push.valid = acc && (run_len != '0);
        if (keep == '0) begin
            o_push.run.bytes = '0;
            o_push.run.cnt   = utf8rd_pkg::RUN_CNT_W'(1);
            o_push.run.flag  = 1'b1;
        end else begin
            o_push.run.bytes = run_bytes;
            o_push.run.cnt   = keep;
            o_push.run.flag  = n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '1;
            r_count <= '0;
            r_over  <= 1'b0;
            r_lead  <= '0;
            r_need  <= '0;
            r_seen  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.output_limit;
            end
            if (acc) begin
                r_count <= n_count;
                r_over  <= n_over;
                r_lead  <= n_lead;
                r_need  <= n_need;
                r_seen  <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && hold_wr) begin
            r_held[r_seen[0]] <= b;
        end
    end

    `U8RD_ASSERT_IMP(a_idle_no_tails, i_clk, i_rst_n, r_need == 2'd0, r_seen == 2'd0)
    `U8RD_ASSERT_NXT(a_over_sticky, i_clk, i_rst_n, r_over, r_over)

endmodule

@@ hw/rtl/utf8rd_queue.sv @@
// Short queue of decoded runs between the front end and the serializer.
// Depends on utf8rd_pkg and the assertion header.
`include "utf8_replacement_decoder_assert.svh"

module utf8rd_queue #(
    parameter int unsigned DEPTH = utf8rd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utf8rd_pkg::t_push  i_push,
    output logic               o_ready,
    output logic               o_valid,
    output utf8rd_pkg::t_run   o_head,
    input  logic               i_pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    utf8rd_pkg::t_run r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_ready = r_count != CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= CW'(r_count + 1'b1);
                2'b01:   r_count <= CW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    `U8RD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push.valid, r_count != CW'(DEPTH))
    `U8RD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

@@ hw/rtl/utf8rd_back.sv @@
// Back end: sends run bytes one per cycle while o_out is ready, via an output register.
// Depends on utf8rd_pkg, utf8rd_if and the assertion header.
`include "utf8_replacement_decoder_assert.svh"

module utf8rd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  utf8rd_pkg::t_run  i_head,
    output logic              o_pop,
    utf8rd_out_if.source      o_out
);

    localparam int unsigned IW = $clog2(utf8rd_pkg::RUN_MAX);

    logic [IW-1:0] r_idx;
    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          r_flag;
    logic          advance;
    logic          last;

    assign advance = !r_valid || o_out.ready;
    assign last    = utf8rd_pkg::RUN_CNT_W'(r_idx) + utf8rd_pkg::RUN_CNT_W'(1) == i_head.cnt;
    assign o_pop   = advance && i_q_valid && last;

    assign o_out.valid          = r_valid;
    assign o_out.out_byte       = r_byte;
    assign o_out.last_of_run    = r_last;
    assign o_out.limit_exceeded = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= last ? '0 : IW'(r_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_q_valid) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= last;
            r_flag <= i_head.flag;
        end
    end

    `U8RD_ASSERT_IMP(a_idx_in_run, i_clk, i_rst_n, i_q_valid,
        utf8rd_pkg::RUN_CNT_W'(r_idx) < i_head.cnt)

endmodule

@@ hw/rtl/utf8_replacement_decoder.sv @@
// UTF-8 decoder with replacement: front end, run queue and byte serializer.
// An accepted item is written to the queue, then its first byte goes to the output register.
// Throughput: one item per cycle while o_out is ready and each item yields at most one byte;
// an item that yields more bytes holds the single output byte register until its last is sent.
// Reset (synchronous, active low) clears the pending sequence, byte count, overflow flag
// and queue, and sets the output limit to FFFFFFFF.
module utf8_replacement_decoder #(
    parameter int unsigned QUEUE_DEPTH = utf8rd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8rd_in_if.sink     i_in,
    utf8rd_cfg_if.sink    i_cfg,
    utf8rd_out_if.source  o_out
);

    utf8rd_pkg::t_push push;
    utf8rd_pkg::t_run  head;
    logic              q_ready;
    logic              q_valid;
    logic              pop;

    utf8rd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_push    (push)
    );

    utf8rd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    utf8rd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
